// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker module of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define OAID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define OAID_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hdl/oaid_pkg.sv =====
// Package for the ordered array: sizes, codes, beat structs and cell command.
// No dependencies.
`default_nettype none

package oaid_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 7;
    localparam int FILL_W     = 7;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_op_t;

    typedef struct packed {
        mode_t                      mode;
        logic [POS_W-1:0]           position;
        logic signed [WORD_W-1:0]   word_in;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]   word_out;
        status_t                    status;
        logic [FILL_W-1:0]          fill;
    } rsp_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_op_t                   op;
        logic [IDX_W-1:0]           at;
        logic signed [WORD_W-1:0]   word;
        logic                       rd_en;
        logic [IDX_W-1:0]           rd_at;
    } cell_cmd_t;

    // Request outcome from the controller.
    typedef struct packed {
        status_t                    status;
        logic [FILL_W-1:0]          fill;
    } ctrl_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/oaid_cell.sv =====
// One entry of the ordered array: holds a word, shifts with its neighbors.
// Depends on oaid_pkg.
`default_nettype none

module oaid_cell
    import oaid_pkg::*;
(
    input  wire logic                       aclk,
    input  wire cell_cmd_t                  cmd,
    input  wire logic [IDX_W-1:0]           cell_idx,
    input  wire logic signed [WORD_W-1:0]   left_word,
    input  wire logic signed [WORD_W-1:0]   right_word,
    output logic signed [WORD_W-1:0]        word_q,
    output logic signed [WORD_W-1:0]        rd_word
);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    // Pick the next word: hold, take the lower neighbor, the new word, or the upper neighbor
    always_comb begin
        word_next = word_reg;
        unique case (cmd.op)
            CELL_HOLD: begin
                word_next = word_reg;
            end
            CELL_INSERT: begin
                if (cell_idx > cmd.at) begin
                    word_next = left_word;
                end else if (cell_idx == cmd.at) begin
                    word_next = cmd.word;
                end
            end
            CELL_DELETE: begin
                if (cell_idx >= cmd.at) begin
                    word_next = right_word;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // Drive the read bus only when addressed
    assign word_q  = word_reg;
    assign rd_word = (cmd.rd_en && (cell_idx == cmd.rd_at)) ? word_reg : '0;

endmodule

`default_nettype wire

// ===== hdl/oaid_ctrl.sv =====
// Request decode and fill count: checks bounds, issues the cell command.
// Depends on oaid_pkg.
`default_nettype none

module oaid_ctrl
    import oaid_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   accept,
    input  wire req_t   req,
    output cell_cmd_t   cmd,
    output ctrl_rsp_t   rsp
);

    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic [CMP_W-1:0] used_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cap_ext;
    logic             full;
    cell_cmd_t        cmd_raw;

    assign used_ext = CMP_W'(used_reg);
    assign pos_ext  = CMP_W'(req.position);
    assign cap_ext  = CMP_W'(CAPACITY);
    assign full     = (used_ext == cap_ext);

    // Decode the request against the current count
    always_comb begin
        rsp.status    = ST_OK;
        used_next     = used_reg;
        cmd_raw.op    = CELL_HOLD;
        cmd_raw.at    = pos_ext[IDX_W-1:0];
        cmd_raw.word  = req.word_in;
        cmd_raw.rd_en = 1'b0;
        cmd_raw.rd_at = pos_ext[IDX_W-1:0];
        unique case (req.mode)
            MODE_APPEND: begin
                if (full) begin
                    rsp.status = ST_FULL;
                end else begin
                    cmd_raw.op = CELL_INSERT;
                    cmd_raw.at = used_reg[IDX_W-1:0];
                    used_next  = used_reg + CNT_W'(1);
                end
            end
            MODE_INSERT: begin
                priority if (pos_ext > used_ext) begin
                    rsp.status = ST_RANGE;
                end else if (full) begin
                    rsp.status = ST_FULL;
                end else begin
                    cmd_raw.op = CELL_INSERT;
                    used_next  = used_reg + CNT_W'(1);
                end
            end
            MODE_DELETE: begin
                if (pos_ext >= used_ext) begin
                    rsp.status = ST_RANGE;
                end else begin
                    cmd_raw.op = CELL_DELETE;
                    used_next  = used_reg - CNT_W'(1);
                end
            end
            MODE_READ: begin
                if ((pos_ext >= used_ext) || (pos_ext >= cap_ext)) begin
                    rsp.status = ST_RANGE;
                end else begin
                    cmd_raw.rd_en = 1'b1;
                end
            end
            default: begin
                rsp.status = ST_OK;
            end
        endcase
        // Report the count left by this request
        rsp.fill = FILL_W'(used_next);
    end

    // Let the cells move only on an accepted beat
    always_comb begin
        cmd = cmd_raw;
        if (!accept) begin
            cmd.op = CELL_HOLD;
        end
    end

    // Advance the count on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (accept) begin
            used_reg <= used_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ordered_array_insert_delete.sv =====
// Top level of the ordered array: controller, row of cells, read tree, result stage.
// Depends on oaid_pkg, oaid_ctrl and oaid_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  s_      | in        | s_valid / s_ready  | s_req: mode, position, word_in
//  m_      | out       | m_valid / m_ready  | m_rsp: word_out, status, fill
//
// One request per cycle while the result is not stalled; every request yields its result
// through stage one and the result register, which register the two read tree levels.
// Every cell shifts at the clock edge that accepts an insert or delete.
// Reset clears the fill count and the valid flags; entries hold no reset value.
// A stalled result holds both pipeline stages and drops s_ready.
`default_nettype none

module ordered_array_insert_delete
    import oaid_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire req_t   s_req,
    output logic        m_valid,
    input  wire logic   m_ready,
    output rsp_t        m_rsp
);

    localparam int PAD = GROUPS * GROUP_SIZE;

    logic                       advance;
    logic                       accept;
    cell_cmd_t                  cmd;
    ctrl_rsp_t                  crsp;
    logic signed [WORD_W-1:0]   cell_word [CAPACITY];
    logic signed [WORD_W-1:0]   cell_rd   [PAD];
    logic signed [WORD_W-1:0]   part_next [GROUPS];
    logic signed [WORD_W-1:0]   part_reg  [GROUPS];
    logic signed [WORD_W-1:0]   rd_next;
    logic                       s1_valid_reg;
    ctrl_rsp_t                  s1_rsp_reg;
    logic                       m_valid_reg;
    rsp_t                       m_rsp_reg;

    // Move the whole pipeline unless the result is stalled
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    oaid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .req     (s_req),
        .cmd     (cmd),
        .rsp     (crsp)
    );

    // Row of cells, each wired to its neighbors; an end cell takes its own word for the missing one
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;
        if (k == 0) begin : g_first
            assign left_w = cell_word[k];
        end else begin : g_mid_l
            assign left_w = cell_word[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_w = cell_word[k];
        end else begin : g_mid_r
            assign right_w = cell_word[k+1];
        end
        oaid_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .cell_idx   (IDX_W'(k)),
            .left_word  (left_w),
            .right_word (right_w),
            .word_q     (cell_word[k]),
            .rd_word    (cell_rd[k])
        );
    end

    // Pad the read bus to a whole number of groups
    for (genvar k = CAPACITY; k < PAD; k++) begin : g_pad
        assign cell_rd[k] = '0;
    end

    // First tree level: OR each group of cells
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            part_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                part_next[g] = part_next[g] | cell_rd[g*GROUP_SIZE + j];
            end
        end
    end

    // Second tree level: OR the group results
    always_comb begin
        rd_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            rd_next = rd_next | part_reg[g];
        end
    end

    // Stage one: status, fill and group words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_rsp_reg <= crsp;
            for (int g = 0; g < GROUPS; g++) begin
                part_reg[g] <= part_next[g];
            end
        end
    end

    // Stage two: result register, held while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_rsp_reg.word_out <= rd_next;
            m_rsp_reg.status   <= s1_rsp_reg.status;
            m_rsp_reg.fill     <= s1_rsp_reg.fill;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

`default_nettype wire

// ===== hdl/oaid_checker.sv =====
// Port-level checker for the ordered array, bound to the top level.
// Depends on oaid_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module oaid_checker
    import oaid_pkg::*;
(
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    s_valid,
    input wire logic    s_ready,
    input wire req_t    s_req,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire rsp_t    m_rsp
);

    logic unused_ok;
    assign unused_ok = s_valid & s_ready & (|s_req);

    // A full report comes only when the count sits at capacity
    `OAID_ASSERT_IMP(a_full_at_cap, aclk, aresetn, m_valid && (m_rsp.status == ST_FULL), m_rsp.fill == FILL_W'(CAPACITY))

    // Only a successful read carries a nonzero word
    `OAID_ASSERT_IMP(a_word_only_ok, aclk, aresetn, m_valid && (m_rsp.word_out != '0), m_rsp.status == ST_OK)

    // A stalled result beat holds
    `OAID_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rsp))

endmodule

bind ordered_array_insert_delete oaid_checker u_oaid_checker (.*);

`default_nettype wire
